// ===== rtl/core/rsb_pkg.sv =====
// Shared types and constants of the radial shell power binning core.
package rsb_pkg;

   // Field widths
   localparam int PSUM_W = 64;
   localparam int RSUM_W = 48;
   localparam int CNT_W  = 23;

   // Saturation limits
   localparam logic [PSUM_W-1:0] PSUM_MAX = '1;
   localparam logic [RSUM_W-1:0] RSUM_MAX = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

   // 2*pi in Q3.29 and the rounding half for the >> 29
   localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
   localparam logic [63:0] ROUND_HALF = 64'h0000_0000_1000_0000;

   // Serial square root: result bits (radicand is twice as wide)
   localparam int SQ_RW = 24;
   // Serial divider: dividend / quotient bits
   localparam int DIV_DW = 64;

   // Configuration register byte addresses
   localparam logic [2:0] ADDR_GRID_SIZE   = 3'd0;
   localparam logic [2:0] ADDR_POWER_SCALE = 3'd4;

   // Request function codes
   localparam logic FUNC_ACCUM = 1'b0;
   localparam logic FUNC_EMIT  = 1'b1;

   // One shell bin as stored
   typedef struct packed {
      logic [PSUM_W-1:0] psum;
      logic [RSUM_W-1:0] rsum;
      logic [CNT_W-1:0]  cnt;
   } bin_entry_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FOLD,
      ST_SQ_START,
      ST_SQ_WAIT,
      ST_RD,
      ST_MUL,
      ST_WR,
      ST_EREAD,
      ST_ECHK,
      ST_DIVP,
      ST_MP0,
      ST_MP1,
      ST_MP2,
      ST_DIVR,
      ST_WN0,
      ST_WN1,
      ST_WN2,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/core/radial_shell_power_binning_core.sv =====
// Spherically averaged power spectrum binning. A func 0 transaction folds the grid indices,
// finds the rounded radius with a bit-serial square root and adds the squared magnitude,
// Q8.16 radius and a count into one shell bin, unless the indices fall outside the grid
// or the radius outside the active shells. A func 1 transaction walks every active bin,
// with two serial divisions and four passes through the one shared 32x32 multiplier per
// occupied bin, then clears all bins together. The request side stalls for the whole of
// each transaction; one result register lets a finished bin wait while the next is built.
module radial_shell_power_binning_core #(
   parameter int GRID_MAX  = 128,
   parameter int BIN_COUNT = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [6:0]  req_x_index,
   input  logic [6:0]  req_y_index,
   input  logic [6:0]  req_z_index,
   input  logic signed [23:0] req_coef_real,
   input  logic signed [23:0] req_coef_imag,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_bin_number,
   output logic [63:0] rsp_mean_power,
   output logic [31:0] rsp_mean_wavenumber,
   output logic [22:0] rsp_bin_count,
   output logic        rsp_last_bin,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import rsb_pkg::*;

   localparam int AW   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
   localparam int NB_W = $clog2(BIN_COUNT + 1);
   localparam logic [7:0] GRID_TOP = 8'(GRID_MAX);
   localparam logic [6:0] BIN_TOP  = 7'(BIN_COUNT);

   // Configuration registers
   logic [7:0]  grid_ff;
   logic [31:0] scale_ff;
   logic        cfg_wr;

   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff  <= 8'd128;
         scale_ff <= '1;
      end else if (cfg_wr) begin
         if (paddr[2] == ADDR_POWER_SCALE[2]) begin
            scale_ff <= pwdata;
         end else begin
            grid_ff <= pwdata[7:0];
         end
      end
   end

   always_comb begin
      if (paddr[2] == ADDR_POWER_SCALE[2]) begin
         prdata = scale_ff;
      end else begin
         prdata = {24'd0, grid_ff};
      end
   end

   // Effective grid, its half and the number of active bins
   logic [7:0] n_eff;
   logic [6:0] half_n;
   logic [7:0] n_less1;
   logic [6:0] nb_raw;
   logic [6:0] nb7;

   always_comb begin
      if (grid_ff < 8'd2) begin
         n_eff = 8'd2;
      end else if (grid_ff > GRID_TOP) begin
         n_eff = GRID_TOP;
      end else begin
         n_eff = grid_ff;
      end
      half_n  = n_eff[7:1];
      n_less1 = n_eff - 8'd1;
      nb_raw  = n_less1[7:1];
      nb7     = (nb_raw > BIN_TOP) ? BIN_TOP : nb_raw;
   end

   // Datapath registers
   state_type          state_ff, state_in;
   logic [6:0]         x_ff, y_ff, z_ff;
   logic [23:0]        re_ff, im_ff;
   logic [14:0]        s_ff, s_in;
   logic [NB_W-1:0]    bin_ff, bin_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        mp_ff, mp_in;
   logic [RSUM_W-1:0]  mr_ff, mr_in;
   logic [31:0]        wn_ff, wn_in;
   logic [63:0]        prod_ff;
   logic [31:0]        mul_a, mul_b;

   // Output register
   logic               rsp_valid_ff;
   logic [5:0]         rsp_bin_ff;
   logic [63:0]        rsp_power_ff;
   logic [31:0]        rsp_wave_ff;
   logic [CNT_W-1:0]   rsp_cnt_ff;
   logic               rsp_last_ff;
   logic               out_free;
   logic               out_load;
   logic               out_last;

   // Serial square root and divider
   logic               sq_start, sq_busy;
   logic [SQ_RW-1:0]   sq_root;
   logic               div_start, div_busy;
   logic [DIV_DW-1:0]  div_dividend, div_quot;
   logic [CNT_W-1:0]   div_divisor;

   // Bin store
   logic               mem_clear, mem_rd_en, mem_wr_en;
   logic [AW-1:0]      mem_rd_addr;
   bin_entry_type      mem_rd_data, mem_wr_data;

   logic               accept;
   logic [23:0]        re_mag, im_mag;
   logic [7:0]         x_dist, y_dist;
   logic [6:0]         x_fold, y_fold;
   logic               in_grid;
   logic [8:0]         q_root;
   logic [9:0]         r_round;
   logic [9:0]         r_less1;
   logic [63:0]        pw_sum;
   logic [64:0]        psum_ext;
   logic [RSUM_W:0]    rsum_ext;
   logic [63:0]        wn_full;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Magnitude of the signed coefficient parts
   assign re_mag = req_coef_real[23] ? 24'(-req_coef_real) : 24'(req_coef_real);
   assign im_mag = req_coef_imag[23] ? 24'(-req_coef_imag) : 24'(req_coef_imag);

   // Fold the first two axes to their distance from zero
   always_comb begin
      x_dist  = n_eff - {1'b0, x_ff};
      y_dist  = n_eff - {1'b0, y_ff};
      x_fold  = (x_dist < {1'b0, x_ff}) ? x_dist[6:0] : x_ff;
      y_fold  = (y_dist < {1'b0, y_ff}) ? y_dist[6:0] : y_ff;
      in_grid = ({1'b0, x_ff} < n_eff) && ({1'b0, y_ff} < n_eff) && (z_ff <= half_n);
   end

   // Rounded radius from the Q8.16 root: q = floor(2*sqrt(s)), r = (q+1)/2
   assign q_root  = sq_root[SQ_RW-1:15];
   assign r_round = ({1'b0, q_root} + 10'd1) >> 1;
   assign r_less1 = r_round - 10'd1;

   assign pw_sum  = acc_ff + prod_ff;
   assign wn_full = acc_ff + {prod_ff[31:0], 32'd0} + ROUND_HALF;

   // Sequencer: next state and unit controls
   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      bin_in       = bin_ff;
      acc_in       = acc_ff;
      mp_in        = mp_ff;
      mr_in        = mr_ff;
      wn_in        = wn_ff;
      mul_a        = '0;
      mul_b        = '0;
      sq_start     = 1'b0;
      div_start    = 1'b0;
      div_dividend = DIV_DW'(mem_rd_data.psum);
      div_divisor  = mem_rd_data.cnt;
      mem_clear    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = bin_ff[AW-1:0];
      mem_wr_en    = 1'b0;
      mem_wr_data  = mem_rd_data;
      out_load     = 1'b0;
      out_last     = (bin_ff == NB_W'(nb7 - 7'd1));
      psum_ext     = {1'b0, mem_rd_data.psum} + {1'b0, pw_sum};
      rsum_ext     = {1'b0, mem_rd_data.rsum} + (RSUM_W+1)'(sq_root);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_EMIT) begin
                  bin_in = '0;
                  if (nb7 == 7'd0) begin
                     mem_clear = 1'b1;
                  end else begin
                     state_in = ST_EREAD;
                  end
               end else begin
                  state_in = ST_FOLD;
               end
            end
         end
         ST_FOLD: begin
            s_in = 15'(14'(x_fold) * 14'(x_fold)) + 15'(14'(y_fold) * 14'(y_fold))
                 + 15'(14'(z_ff) * 14'(z_ff));
            state_in = in_grid ? ST_SQ_START : ST_IDLE;
         end
         ST_SQ_START: begin
            sq_start = 1'b1;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (!sq_busy) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            // Drop radii outside the active shells; else fetch the bin and square re
            if (r_round == 10'd0 || r_round > {3'd0, nb7}) begin
               state_in = ST_IDLE;
            end else begin
               bin_in      = NB_W'(r_less1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = AW'(r_less1);
               mul_a       = {8'd0, re_ff};
               mul_b       = {8'd0, re_ff};
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in   = prod_ff;
            mul_a    = {8'd0, im_ff};
            mul_b    = {8'd0, im_ff};
            state_in = ST_WR;
         end
         ST_WR: begin
            // Saturating read-modify-write of the bin
            mem_wr_en = 1'b1;
            mem_wr_data.psum = psum_ext[64] ? PSUM_MAX : psum_ext[63:0];
            mem_wr_data.rsum = rsum_ext[RSUM_W] ? RSUM_MAX : rsum_ext[RSUM_W-1:0];
            mem_wr_data.cnt  = (mem_rd_data.cnt == CNT_MAX) ? CNT_MAX
                             : mem_rd_data.cnt + CNT_W'(1);
            state_in = ST_IDLE;
         end
         ST_EREAD: begin
            mem_rd_en = 1'b1;
            state_in  = ST_ECHK;
         end
         ST_ECHK: begin
            if (mem_rd_data.cnt == '0) begin
               mp_in    = '0;
               mr_in    = RSUM_W'({bin_ff, 16'd0}) + RSUM_W'(17'h10000);
               state_in = ST_WN0;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVP;
            end
         end
         ST_DIVP: begin
            if (!div_busy) begin
               state_in = ST_MP0;
            end
         end
         ST_MP0: begin
            mul_a    = div_quot[31:0];
            mul_b    = scale_ff;
            state_in = ST_MP1;
         end
         ST_MP1: begin
            acc_in   = {32'd0, prod_ff[63:32]};
            mul_a    = div_quot[63:32];
            mul_b    = scale_ff;
            state_in = ST_MP2;
         end
         ST_MP2: begin
            mp_in        = pw_sum;
            div_start    = 1'b1;
            div_dividend = DIV_DW'(mem_rd_data.rsum);
            state_in     = ST_DIVR;
         end
         ST_DIVR: begin
            if (!div_busy) begin
               mr_in    = div_quot[RSUM_W-1:0];
               state_in = ST_WN0;
            end
         end
         ST_WN0: begin
            mul_a    = mr_ff[31:0];
            mul_b    = TWO_PI_Q29;
            state_in = ST_WN1;
         end
         ST_WN1: begin
            acc_in   = prod_ff;
            mul_a    = {{(64-RSUM_W){1'b0}}, mr_ff[RSUM_W-1:32]};
            mul_b    = TWO_PI_Q29;
            state_in = ST_WN2;
         end
         ST_WN2: begin
            wn_in    = wn_full[60:29];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hand the bin to the result register, then advance or finish
            if (out_free) begin
               out_load = 1'b1;
               if (out_last) begin
                  mem_clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  bin_in   = bin_ff + NB_W'(1);
                  state_in = ST_EREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the transaction and hold the working values
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff  <= req_x_index;
         y_ff  <= req_y_index;
         z_ff  <= req_z_index;
         re_ff <= re_mag;
         im_ff <= im_mag;
      end
      s_ff    <= s_in;
      bin_ff  <= bin_in;
      acc_ff  <= acc_in;
      mp_ff   <= mp_in;
      mr_ff   <= mr_in;
      wn_ff   <= wn_in;
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_bin_ff   <= 6'(bin_ff);
         rsp_power_ff <= mp_ff;
         rsp_wave_ff  <= wn_ff;
         rsp_cnt_ff   <= mem_rd_data.cnt;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_bin_number      = rsp_bin_ff;
   assign rsp_mean_power      = rsp_power_ff;
   assign rsp_mean_wavenumber = rsp_wave_ff;
   assign rsp_bin_count       = rsp_cnt_ff;
   assign rsp_last_bin        = rsp_last_ff;

   rsb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand ({1'b0, s_ff, 32'd0}),
      .busy     (sq_busy),
      .root     (sq_root)
   );

   rsb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   rsb_bin_mem #(
      .DEPTH (BIN_COUNT),
      .AW    (AW)
   ) u_bin_mem (
      .clock     (clock),
      .reset     (reset),
      .clear_all (mem_clear),
      .rd_en     (mem_rd_en),
      .rd_addr   (mem_rd_addr),
      .rd_data   (mem_rd_data),
      .wr_en     (mem_wr_en),
      .wr_addr   (bin_ff[AW-1:0]),
      .wr_data   (mem_wr_data)
   );

endmodule

// ===== rtl/core/rsb_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module rsb_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [2*rsb_pkg::SQ_RW-1:0]    radicand,
   output logic                           busy,
   output logic [rsb_pkg::SQ_RW-1:0]      root
);
   import rsb_pkg::*;

   localparam int CW = $clog2(SQ_RW);

   logic [2*SQ_RW-1:0] rad_ff, rad_in;
   logic [SQ_RW:0]     rem_ff, rem_in;
   logic [SQ_RW-1:0]   root_ff, root_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [SQ_RW+2:0]   rem_next;
   logic [SQ_RW+2:0]   trial;

   // One step: bring down two bits, try root*4+1
   always_comb begin
      rem_next = {rem_ff, rad_ff[2*SQ_RW-1 -: 2]};
      trial    = {1'b0, root_ff, 2'b01};
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(SQ_RW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[2*SQ_RW-3:0], 2'b00};
         if (rem_next >= trial) begin
            rem_in  = (SQ_RW+1)'(rem_next - trial);
            root_in = {root_ff[SQ_RW-2:0], 1'b1};
         end else begin
            rem_in  = (SQ_RW+1)'(rem_next);
            root_in = {root_ff[SQ_RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ===== rtl/core/rsb_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module rsb_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rsb_pkg::DIV_DW-1:0]    dividend,
   input  logic [rsb_pkg::CNT_W-1:0]     divisor,
   output logic                          busy,
   output logic [rsb_pkg::DIV_DW-1:0]    quotient
);
   import rsb_pkg::*;

   localparam int CW = $clog2(DIV_DW);

   logic [DIV_DW-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [CNT_W:0]    rem_next;

   // Shift the dividend out at the top and the quotient in at the bottom
   always_comb begin
      rem_next = {rem_ff, dvd_ff[DIV_DW-1]};
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = CW'(DIV_DW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_next >= {1'b0, dvs_ff}) begin
            rem_in = CNT_W'(rem_next - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[DIV_DW-2:0], 1'b1};
         end else begin
            rem_in = rem_next[CNT_W-1:0];
            dvd_in = {dvd_ff[DIV_DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

endmodule

// ===== rtl/core/rsb_bin_mem.sv =====
// Shell bin store: one-port-write, registered-read memory with per-entry valid bits.
module rsb_bin_mem #(
   parameter int DEPTH = 63,
   parameter int AW    = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear_all,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output rsb_pkg::bin_entry_type        rd_data,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  rsb_pkg::bin_entry_type        wr_data
);
   import rsb_pkg::*;

   bin_entry_type mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   bin_entry_type    rd_data_ff;

   // Valid bits: reset and emit clear every bin at once
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read; a bin never written reads as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
